// File: hdl/ri2a_pkg.sv
// shared constants, types and helpers for the radix integer to ascii digit converter
package ri2a_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int IN_W        = VALUE_BITS + RADIX_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int IDX_W       = $clog2(VALUE_BITS);
    localparam int BIT_W       = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] DEC_LIMIT = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(65);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DEC_LIMIT) begin
            res = CHAR_ZERO + CHAR_W'(d);
        end else begin
            res = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return res;
    endfunction

endpackage

// File: hdl/radix_integer_to_ascii_digits_top.sv
// top level: converts an unsigned integer to ascii digits in a chosen radix
//
// Each input transaction carries a value and a radix (0 and 1 are taken as 2, anything
// above 36 as 36). The block emits one output transaction per digit, most significant
// first, '0'-'9' then 'A'-'Z', with tlast on the final digit; a value of zero gives a
// single '0'. Digits come from a shared bit-serial restoring divider that works through
// all VALUE_BITS (31) bits of the value on each division. The digits are stacked least
// significant first and read back in reverse. s_axis_tready is high only in the idle
// state, so a new item is taken only once the last digit of the previous one has been
// loaded into the output register, where it may still wait for m_axis_tready.
module radix_integer_to_ascii_digits_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ri2a_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value, radix, zero pad
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ri2a_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // digit_char, zero pad
    output logic                                 m_axis_tlast
);

    localparam int VB  = ri2a_pkg::VALUE_BITS;
    localparam int RW  = ri2a_pkg::RADIX_W;
    localparam int CW  = ri2a_pkg::CHAR_W;
    localparam int NW  = ri2a_pkg::CNT_W;
    localparam int XW  = ri2a_pkg::IDX_W;
    localparam int BW  = ri2a_pkg::BIT_W;

    ri2a_pkg::t_state r_state, n_state;

    logic [VB-1:0] r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_radix, n_radix;
    logic [BW-1:0] r_bit, n_bit;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_stack [VB];

    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_char, n_out_char;
    logic          r_out_last, n_out_last;

    logic          in_acc;
    logic [RW:0]   rem_sh;
    logic          rem_ge;
    logic [RW-1:0] rem_new;
    logic [VB-1:0] quo_new;
    logic          push;
    logic          pop;
    logic [NW-1:0] cnt_m1;

    assign s_axis_tready = (r_state == ri2a_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // one restoring division step
    assign rem_sh  = {r_rem, r_quo[VB-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_radix});
    assign rem_new = rem_ge ? RW'(rem_sh - {1'b0, r_radix}) : rem_sh[RW-1:0];
    assign quo_new = {r_quo[VB-2:0], rem_ge};

    assign push   = (r_state == ri2a_pkg::ST_DIV) && (r_bit == '0);
    assign pop    = (r_state == ri2a_pkg::ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign cnt_m1 = r_cnt - NW'(1);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ri2a_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_quo   = s_axis_tdata[VB-1:0];
                    n_radix = ri2a_pkg::clamp_radix(s_axis_tdata[VB+RW-1:VB]);
                    n_rem   = '0;
                    n_bit   = BW'(VB - 1);
                    n_cnt   = '0;
                    n_state = ri2a_pkg::ST_DIV;
                end
            end
            ri2a_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_cnt = r_cnt + NW'(1);
                    n_rem = '0;
                    n_quo = quo_new;
                    n_bit = BW'(VB - 1);
                    if (quo_new == '0) begin
                        n_state = ri2a_pkg::ST_EMIT;
                    end
                end else begin
                    n_rem = rem_new;
                    n_quo = quo_new;
                    n_bit = r_bit - BW'(1);
                end
            end
            ri2a_pkg::ST_EMIT: begin
                if (pop) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ri2a_pkg::digit_to_ascii(r_stack[cnt_m1[XW-1:0]]);
                    n_out_last  = (r_cnt == NW'(1));
                    n_cnt       = cnt_m1;
                    if (r_cnt == NW'(1)) begin
                        n_state = ri2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ri2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ri2a_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (push) begin
            r_stack[r_cnt[XW-1:0]] <= rem_new;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ri2a_pkg::OUT_TDATA_W - CW){1'b0}}, r_out_char};
    assign m_axis_tlast  = r_out_last;

    // remainder always stays below the radix while dividing
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ri2a_pkg::ST_DIV) |-> (r_rem < r_radix))
        else $error("remainder not below radix");

    // digit count never exceeds the value width
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= NW'(VB)))
        else $error("digit count overflow");

    // an accepted transaction starts a fresh division
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (r_state == ri2a_pkg::ST_DIV) && (r_cnt == '0))
        else $error("division not started after input transaction");

endmodule

// File: dv/testbench.sv
// testbench for the radix integer to ascii digit converter: directed, random and backpressure tests
`timescale 1ns / 100ps

module testbench;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 2500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 100;
    localparam int PRINT_CAP      = 100;

    typedef struct {
        logic [ri2a_pkg::CHAR_W-1:0] digit_char;
        logic                        last;
    } t_digit;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [ri2a_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // value, radix, zero pad
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [ri2a_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // digit_char, zero pad
    logic                             m_axis_tlast;

    t_digit digit_q[$];
    int     err_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;
    bit     hold_req;
    int     quiet_cycles;

    radix_integer_to_ascii_digits_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
    end

    always begin
        #HALF_PERIOD i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // digits of value in the clamped radix, most significant first
    function automatic void predict_digits(input logic [ri2a_pkg::VALUE_BITS-1:0] value,
                                           input logic [ri2a_pkg::RADIX_W-1:0] radix);
        logic [ri2a_pkg::RADIX_W-1:0]    base;
        logic [ri2a_pkg::VALUE_BITS-1:0] rest;
        logic [ri2a_pkg::RADIX_W-1:0]    stack[$];
        logic [ri2a_pkg::RADIX_W-1:0]    d;
        t_digit                          e;
        base = radix;
        if (radix < ri2a_pkg::RADIX_MIN) begin
            base = ri2a_pkg::RADIX_MIN;
        end else if (radix > ri2a_pkg::RADIX_MAX) begin
            base = ri2a_pkg::RADIX_MAX;
        end
        rest = value;
        do begin
            stack.push_back(ri2a_pkg::RADIX_W'(rest % ri2a_pkg::VALUE_BITS'(base)));
            rest = rest / ri2a_pkg::VALUE_BITS'(base);
        end while (rest != '0);
        for (int k = stack.size() - 1; k >= 0; k--) begin
            d = stack[k];
            if (d < ri2a_pkg::DEC_LIMIT) begin
                e.digit_char = ri2a_pkg::CHAR_ZERO + ri2a_pkg::CHAR_W'(d);
            end else begin
                e.digit_char = ri2a_pkg::CHAR_A + ri2a_pkg::CHAR_W'(d - ri2a_pkg::DEC_LIMIT);
            end
            e.last = (k == 0);
            digit_q.push_back(e);
        end
    endfunction

    function automatic logic [ri2a_pkg::IN_TDATA_W-1:0] pack_item(
        input logic [ri2a_pkg::VALUE_BITS-1:0] value,
        input logic [ri2a_pkg::RADIX_W-1:0] radix);
        logic [ri2a_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[ri2a_pkg::VALUE_BITS-1:0]              = value;
        word[ri2a_pkg::IN_W-1:ri2a_pkg::VALUE_BITS] = radix;
        return word;
    endfunction

    // called at a falling edge, returns at a falling edge with tvalid low
    task automatic send_item(input logic [ri2a_pkg::VALUE_BITS-1:0] value,
                             input logic [ri2a_pkg::RADIX_W-1:0] radix);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pack_item(value, radix);
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_digits(value, radix);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = pack_item(ri2a_pkg::VALUE_BITS'($urandom),
                                  ri2a_pkg::RADIX_W'($urandom));
    endtask

    task automatic wait_drained();
        while (digit_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver side, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_digit e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digit_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digit 0x%02h last %0b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                e = digit_q.pop_front();
                if (m_axis_tdata[ri2a_pkg::CHAR_W-1:0] !== e.digit_char) begin
                    report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                              m_axis_tdata[ri2a_pkg::CHAR_W-1:0],
                                              e.digit_char));
                end
                if (m_axis_tlast !== e.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_axis_tlast, e.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[radix_integer_to_ascii_digits_top] ERROR");
            $finish;
        end
    end

    function automatic logic [ri2a_pkg::VALUE_BITS-1:0] random_value();
        logic [ri2a_pkg::VALUE_BITS-1:0] v;
        v = ri2a_pkg::VALUE_BITS'($urandom);
        case ($urandom_range(3))
            0: v = v >> $urandom_range(ri2a_pkg::VALUE_BITS - 1);
            1: v = ri2a_pkg::VALUE_BITS'($urandom_range(40));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [ri2a_pkg::RADIX_W-1:0] random_radix();
        if ($urandom_range(9) == 0) begin
            return ri2a_pkg::RADIX_W'($urandom);
        end
        return ri2a_pkg::RADIX_W'($urandom_range(ri2a_pkg::RADIX_MAX, ri2a_pkg::RADIX_MIN));
    endfunction

    task automatic test_reset();
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic test_extremes();
        send_item('0, ri2a_pkg::DEC_LIMIT);
        send_item('1, ri2a_pkg::RADIX_MIN);
        send_item('1, ri2a_pkg::RADIX_MAX);
        send_item(ri2a_pkg::VALUE_BITS'(1), ri2a_pkg::RADIX_MIN);
        send_item(ri2a_pkg::VALUE_BITS'(9), ri2a_pkg::DEC_LIMIT);
        send_item(ri2a_pkg::VALUE_BITS'(10), ri2a_pkg::RADIX_W'(11));
        send_item(ri2a_pkg::VALUE_BITS'(35), ri2a_pkg::RADIX_MAX);
        send_item(ri2a_pkg::VALUE_BITS'(36), ri2a_pkg::RADIX_MAX);
        send_item(ri2a_pkg::VALUE_BITS'(32'h2AAA_AAAA), ri2a_pkg::RADIX_MIN);
        send_item(ri2a_pkg::VALUE_BITS'(32'h5555_5555), ri2a_pkg::RADIX_MIN);
        send_item(ri2a_pkg::VALUE_BITS'(1234567890), ri2a_pkg::DEC_LIMIT);
        send_item(ri2a_pkg::VALUE_BITS'(32'h7EDC_BA98), ri2a_pkg::RADIX_W'(16));
        wait_drained();
    endtask

    task automatic test_radix_clamp();
        send_item('0, '0);
        send_item('0, '1);
        send_item(ri2a_pkg::VALUE_BITS'(5), '0);
        send_item(ri2a_pkg::VALUE_BITS'(5), ri2a_pkg::RADIX_W'(1));
        send_item('1, ri2a_pkg::RADIX_W'(37));
        send_item('1, '1);
        send_item(ri2a_pkg::VALUE_BITS'(1295), ri2a_pkg::RADIX_W'(50));
        send_item(ri2a_pkg::VALUE_BITS'(32'h3C3C_3C3C), ri2a_pkg::RADIX_W'(1));
        wait_drained();
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_item(random_value(), random_radix());
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (6) send_item(random_value(), ri2a_pkg::DEC_LIMIT);
        wait_drained();
    endtask

    initial begin
        test_reset();
        test_extremes();
        test_radix_clamp();
        test_random(90, 0, 0);
        test_random(90, 54, 0);
        test_backpressure();
        test_random(90, 0, 54);
        test_random(90, 21, 21);
        if (digit_q.size() != 0) begin
            report_mismatch($sformatf("%0d digits never arrived", digit_q.size()));
        end
        if (err_count == 0) begin
            $display("[radix_integer_to_ascii_digits_top] OK");
        end else begin
            $display("[radix_integer_to_ascii_digits_top] ERROR");
        end
        $finish;
    end

endmodule
